@@ design/path_name_sanitizer_assert.svh @@
// Assertion macros used by the checker file.
`ifndef PATH_NAME_SANITIZER_ASSERT_SVH
`define PATH_NAME_SANITIZER_ASSERT_SVH

// Same-cycle implication under reset.
`define PNS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("path_name_sanitizer: assertion failed");

// Next-cycle implication under reset.
`define PNS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("path_name_sanitizer: assertion failed");

`endif

@@ design/pns_pkg.sv @@
package pns_pkg;

    // Character codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    // Limit register
    localparam int          LIMIT_W        = 9;
    localparam logic [8:0]  LIMIT_CAP      = 9'd256;
    localparam logic [8:0]  LIMIT_RESET    = 9'd256;
    localparam int          ADDR_W         = 3;
    localparam int          DATA_W         = 32;
    localparam int          OUT_DATA_W     = 24;

    // Register index decode (paddr[2] selects the word)
    localparam logic        REG_NAME_LIMIT = 1'b0;

    // One queued event: an optional byte result and an optional final result
    typedef struct packed {
        logic       has_byte;
        logic [7:0] out_byte;
        logic       has_final;
        logic       accepted;
        logic [7:0] out_length;
    } pns_entry_t;

    // Verdict on the pending byte
    typedef struct packed {
        logic       reject;
        logic       emit;
        logic [7:0] out_byte;
    } pns_decide_t;

    function automatic logic is_sep(input logic [7:0] c);
        is_sep = (c == CH_SLASH) || (c == CH_BSLASH);
    endfunction

    // Decide byte c given the following byte n (NUL at end of name)
    function automatic pns_decide_t decide(input logic [7:0] c, input logic [7:0] n,
                                           input logic [7:0] cnt, input logic [8:0] lim);
        pns_decide_t d;
        d.reject   = 1'b0;
        d.emit     = 1'b0;
        d.out_byte = is_sep(c) ? CH_SLASH : c;
        if (((c == CH_DOT) && (n == CH_DOT)) || ((c == CH_COLON) && (n == CH_COLON)))
        begin
            d.reject = 1'b1;
        end
        else if ((c == CH_DOT) && ((n == CH_NUL) || is_sep(n)))
        begin
            d.emit = 1'b0;
        end
        else if (({1'b0, cnt} + 9'd1) >= lim)
        begin
            d.reject = 1'b1;
        end
        else
        begin
            d.emit = 1'b1;
        end
        return d;
    endfunction

endpackage

@@ design/pns_front.sv @@
module pns_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          in_byte,
    input  logic [8:0]          name_limit,
    output logic                push,
    output pns_pkg::pns_entry_t entry
);
    import pns_pkg::*;

    logic [7:0]  pend_byte_reg, pend_byte_next;
    logic        pend_valid_reg, pend_valid_next;
    logic        leading_reg, leading_next;
    logic        after_slash_reg, after_slash_next;
    logic [7:0]  count_reg, count_next;
    logic        rejected_reg, rejected_next;
    logic [8:0]  lim;
    logic        sep;
    pns_decide_t d;

    // Effective limit, capped so the length fits in a byte
    assign lim = (name_limit > LIMIT_CAP) ? LIMIT_CAP : name_limit;
    assign sep = is_sep(in_byte);
    assign d   = decide(pend_byte_reg, in_byte, count_reg, lim);

    // Classify the incoming byte and settle the pending one
    always_comb
    begin
        pend_byte_next   = pend_byte_reg;
        pend_valid_next  = pend_valid_reg;
        leading_next     = leading_reg;
        after_slash_next = after_slash_reg;
        count_next       = count_reg;
        rejected_next    = rejected_reg;
        entry            = '0;
        if (accept)
        begin
            if (in_byte == CH_NUL)
            begin
                // terminator: flush pending byte, then final status
                entry.has_final = 1'b1;
                entry.accepted  = !rejected_reg;
                entry.out_length = count_reg;
                if (!rejected_reg && pend_valid_reg)
                begin
                    if (d.reject)
                    begin
                        entry.accepted = 1'b0;
                    end
                    else if (d.emit)
                    begin
                        entry.has_byte   = 1'b1;
                        entry.out_byte   = d.out_byte;
                        entry.out_length = count_reg + 8'd1;
                    end
                end
                pend_byte_next   = CH_NUL;
                pend_valid_next  = 1'b0;
                leading_next     = 1'b1;
                after_slash_next = 1'b0;
                count_next       = '0;
                rejected_next    = 1'b0;
            end
            else if (!rejected_reg)
            begin
                if (leading_reg)
                begin
                    if (!sep)
                    begin
                        leading_next     = 1'b0;
                        pend_byte_next   = in_byte;
                        pend_valid_next  = 1'b1;
                        after_slash_next = 1'b0;
                    end
                end
                else if (!(sep && after_slash_reg && pend_valid_reg))
                begin
                    if (pend_valid_reg && d.reject)
                    begin
                        rejected_next    = 1'b1;
                        pend_valid_next  = 1'b0;
                        after_slash_next = 1'b0;
                    end
                    else
                    begin
                        if (pend_valid_reg && d.emit)
                        begin
                            entry.has_byte = 1'b1;
                            entry.out_byte = d.out_byte;
                            count_next     = count_reg + 8'd1;
                        end
                        pend_byte_next   = sep ? CH_SLASH : in_byte;
                        pend_valid_next  = 1'b1;
                        after_slash_next = sep;
                    end
                end
            end
        end
    end

    assign push = accept && (entry.has_byte || entry.has_final);

    // Per-name state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_byte_reg   <= CH_NUL;
            pend_valid_reg  <= 1'b0;
            leading_reg     <= 1'b1;
            after_slash_reg <= 1'b0;
            count_reg       <= '0;
            rejected_reg    <= 1'b0;
        end
        else
        begin
            pend_byte_reg   <= pend_byte_next;
            pend_valid_reg  <= pend_valid_next;
            leading_reg     <= leading_next;
            after_slash_reg <= after_slash_next;
            count_reg       <= count_next;
            rejected_reg    <= rejected_next;
        end
    end

endmodule

@@ design/pns_queue.sv @@
module pns_queue #(
    parameter int DEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  pns_pkg::pns_entry_t wr_entry,
    input  logic                pop,
    output pns_pkg::pns_entry_t rd_entry,
    output logic                not_empty,
    output logic                full
);
    import pns_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    pns_entry_t       slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == FULL_CNT);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign rd_entry  = slots_reg[rd_ptr_reg];

    // Pointer and fill tracking
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Slot storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

@@ design/pns_back.sv @@
module pns_back (
    input  logic                clk,
    input  logic                rst_n,
    input  pns_pkg::pns_entry_t head,
    input  logic                head_valid,
    output logic                pop,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [23:0]         m_axis_tdata, // [7:0] out_byte, [8] accepted, [16:9] out_length
    output logic                m_axis_tlast  // end_flag
);
    import pns_pkg::*;

    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       last_reg, last_next;
    logic       acc_reg, acc_next;
    logic [7:0] len_reg, len_next;
    logic       left_valid_reg, left_valid_next;
    logic       left_acc_reg, left_acc_next;
    logic [7:0] left_len_reg, left_len_next;
    logic       load;

    // Output register frees when empty or taken
    assign load = !valid_reg || m_axis_tready;
    assign pop  = load && !left_valid_reg && head_valid;

    // Unpack queued events, byte result before the final result
    always_comb
    begin
        valid_next      = valid_reg;
        byte_next       = byte_reg;
        last_next       = last_reg;
        acc_next        = acc_reg;
        len_next        = len_reg;
        left_valid_next = left_valid_reg;
        left_acc_next   = left_acc_reg;
        left_len_next   = left_len_reg;
        if (load)
        begin
            if (left_valid_reg)
            begin
                valid_next      = 1'b1;
                byte_next       = CH_NUL;
                last_next       = 1'b1;
                acc_next        = left_acc_reg;
                len_next        = left_len_reg;
                left_valid_next = 1'b0;
            end
            else if (head_valid)
            begin
                valid_next = 1'b1;
                if (head.has_byte)
                begin
                    byte_next       = head.out_byte;
                    last_next       = 1'b0;
                    acc_next        = 1'b0;
                    len_next        = '0;
                    left_valid_next = head.has_final;
                    left_acc_next   = head.accepted;
                    left_len_next   = head.out_length;
                end
                else
                begin
                    byte_next = CH_NUL;
                    last_next = 1'b1;
                    acc_next  = head.accepted;
                    len_next  = head.out_length;
                end
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= 1'b0;
            left_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg      <= valid_next;
            left_valid_reg <= left_valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        byte_reg     <= byte_next;
        last_reg     <= last_next;
        acc_reg      <= acc_next;
        len_reg      <= len_next;
        left_acc_reg <= left_acc_next;
        left_len_reg <= left_len_next;
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tlast  = last_reg;
    assign m_axis_tdata  = {7'd0, len_reg, acc_reg, byte_reg};

endmodule

@@ design/path_name_sanitizer.sv @@
// A byte result enters the event queue when the input byte that settles it is taken,
// then moves to the output register. Throughput: one input byte per cycle while the
// queue is not full; the output drains one result per cycle while tready is high.
// A terminator flushing a pending byte gives two results; the event queue absorbs it.
// Reset (rst_n, async, active low): per-name state cleared, queue empty,
// name_limit back to 256.
module path_name_sanitizer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] in_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // [7:0] out_byte, [8] accepted, [16:9] out_length
    output logic        m_axis_tlast,  // end_flag
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import pns_pkg::*;

    logic       limit_reg;
    logic [8:0] name_limit_reg;
    logic       cfg_write;
    logic       accept;
    logic       push;
    logic       pop;
    logic       q_not_empty;
    logic       q_full;
    pns_entry_t wr_entry;
    pns_entry_t head;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign limit_reg = (paddr[2] == REG_NAME_LIMIT);
    assign prdata    = limit_reg ? {23'd0, name_limit_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            name_limit_reg <= LIMIT_RESET;
        end
        else if (cfg_write && limit_reg)
        begin
            name_limit_reg <= pwdata[8:0];
        end
    end

    // Input handshake
    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    pns_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .in_byte    (s_axis_tdata),
        .name_limit (name_limit_reg),
        .push       (push),
        .entry      (wr_entry)
    );

    pns_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_entry  (wr_entry),
        .pop       (pop),
        .rd_entry  (head),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    pns_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .head_valid    (q_not_empty),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

@@ design/pns_checker.sv @@
`include "path_name_sanitizer_assert.svh"

module pns_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic        psel,
    input logic [31:0] prdata
);

    // Stalled output keeps its result
    `PNS_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

    // Byte results carry no status or length
    `PNS_ASSERT_NOW(a_byte_clean, clk, rst_n, m_axis_tvalid && !m_axis_tlast, m_axis_tdata[16:8] == 9'd0)

    // Final results carry a zero byte and no padding
    `PNS_ASSERT_NOW(a_final_clean, clk, rst_n, m_axis_tvalid && m_axis_tlast, m_axis_tdata[7:0] == 8'd0 && m_axis_tdata[23:17] == 7'd0)

    // Register reads never show bits beyond the limit field
    `PNS_ASSERT_NOW(a_read_width, clk, rst_n, psel, prdata[31:9] == 23'd0)

endmodule

bind path_name_sanitizer pns_checker u_pns_checker (.*);
